// ===== design/gga_sentence_field_extractor_defines.svh =====
// Assertion macros for the checker file of the GGA field extractor.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef GGA_SENTENCE_FIELD_EXTRACTOR_DEFINES_SVH
`define GGA_SENTENCE_FIELD_EXTRACTOR_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define GSFE_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gsfe: next-cycle check failed");

// The consequent must hold in the same clock as the antecedent.
`define GSFE_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gsfe: same-cycle check failed");

`endif

// ===== design/gsfe_pkg.sv =====
package gsfe_pkg;

	// Capture counter and capture position width (captures run up to 127 bytes).
	localparam int CNT_W = 7;

	// Beat queue between the front and back stages.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	// Characters of interest.
	localparam logic [7:0] CHAR_G    = 8'h47;
	localparam logic [7:0] CHAR_A    = 8'h41;
	localparam logic [7:0] CHAR_N    = 8'h4E;
	localparam logic [7:0] CHAR_S    = 8'h53;
	localparam logic [7:0] CHAR_ZERO = 8'h30;

	// floor(t / 6) == (t * RECIP6) >> RECIP6_SH for every t below 1024.
	localparam logic [11:0] RECIP6   = 12'd2731;
	localparam int          RECIP6_SH = 14;

	// Field offsets inside a capture (offset 0 is the byte after the header).
	localparam logic [CNT_W-1:0] OFF_HOUR    = 7'd1;
	localparam logic [CNT_W-1:0] OFF_MINUTE  = 7'd3;
	localparam logic [CNT_W-1:0] OFF_SECOND  = 7'd5;
	localparam logic [CNT_W-1:0] OFF_LAT_DEG = 7'd11;
	localparam logic [CNT_W-1:0] OFF_LAT_MIN = 7'd13;
	localparam logic [CNT_W-1:0] OFF_HEMI    = 7'd22;
	localparam logic [CNT_W-1:0] OFF_LON_DEG = 7'd25;
	localparam logic [CNT_W-1:0] OFF_LON_MIN = 7'd27;
	localparam logic [CNT_W-1:0] OFF_FIX     = 7'd38;
	localparam logic [CNT_W-1:0] OFF_SATS    = 7'd40;
	localparam logic [CNT_W-1:0] OFF_HDOP    = 7'd43;
	localparam logic [CNT_W-1:0] OFF_ALT     = 7'd48;

	typedef enum logic [1:0] {
		HDR_IDLE,
		HDR_G,
		HDR_GG
	} hdr_t;

	// One captured byte on its way from the front to the back stage.
	typedef struct packed {
		logic [7:0]       data;
		logic [CNT_W-1:0] pos;
		logic             last;
	} cap_beat_t;

	// Decoded position record.
	typedef struct packed {
		logic [14:0] altitude;
		logic [14:0] hdop;
		logic [11:0] satellites;
		logic [7:0]  fix_quality;
		logic [28:0] lon_fraction;
		logic [11:0] lon_degrees;
		logic [28:0] lat_fraction;
		logic [11:0] lat_degrees;
		logic [11:0] second;
		logic [11:0] minute;
		logic [11:0] hour;
	} rec_t;

endpackage

// ===== design/gsfe_front.sv =====
module gsfe_front #(
	parameter int CAPTURE_BYTES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	output logic                push_valid,
	input  logic                push_ready,
	output gsfe_pkg::cap_beat_t push_beat
);
	import gsfe_pkg::*;

	localparam logic [CNT_W-1:0] CAP_LEN = CNT_W'(CAPTURE_BYTES);

	hdr_t             hdr_q, hdr_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             acc;

	assign s_tready = push_ready;
	assign acc      = s_tvalid && s_tready;

	// Header hunt and capture count.
	always_comb begin
		hdr_d = hdr_q;
		cnt_d = cnt_q;
		if (acc) begin
			if (cnt_q == '0) begin
				unique case (hdr_q)
					HDR_IDLE: begin
						hdr_d = (s_tdata == CHAR_G) ? HDR_G : HDR_IDLE;
					end
					HDR_G: begin
						hdr_d = (s_tdata == CHAR_G) ? HDR_GG : HDR_IDLE;
					end
					HDR_GG: begin
						hdr_d = HDR_IDLE;
						if (s_tdata == CHAR_G) begin
							hdr_d = HDR_GG;
						end else if (s_tdata == CHAR_A) begin
							cnt_d = CAP_LEN;
						end
					end
					default: begin
						hdr_d = HDR_IDLE;
					end
				endcase
			end else begin
				cnt_d = cnt_q - CNT_W'(1);
			end
		end
	end

	// Captured bytes go to the queue tagged with their offset.
	always_comb begin
		push_valid     = acc && (cnt_q != '0);
		push_beat.data = s_tdata;
		push_beat.pos  = CAP_LEN - cnt_q;
		push_beat.last = (cnt_q == CNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= HDR_IDLE;
			cnt_q <= '0;
		end else begin
			hdr_q <= hdr_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

// ===== design/gsfe_fifo.sv =====
module gsfe_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  gsfe_pkg::cap_beat_t wr_beat,
	output logic                rd_valid,
	input  logic                rd_ready,
	output gsfe_pkg::cap_beat_t rd_beat
);
	import gsfe_pkg::*;

	cap_beat_t       mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            do_wr, do_rd;

	assign wr_ready = (count_q != (Q_AW + 1)'(Q_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_beat  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (Q_AW + 1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (Q_AW + 1)'(1);
			end
		end
	end

endmodule

// ===== design/gsfe_back.sv =====
module gsfe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                beat_valid,
	output logic                beat_ready,
	input  gsfe_pkg::cap_beat_t beat,
	output logic                res_valid,
	input  logic                res_ready,
	output gsfe_pkg::rec_t      res_rec,
	output logic                res_ok
);
	import gsfe_pkg::*;

	// Working copy of the fields being accumulated during a capture.
	typedef struct packed {
		rec_t       rec;
		logic       hemi_ok;
		logic [2:0] lat_rem;
		logic [2:0] lon_rem;
	} scratch_t;

	scratch_t sc_q, sc_d;
	rec_t     rec_q;
	logic     ok_q, valid_q;
	logic     pop;
	logic [7:0] dig;

	// Minutes unit: running quotient and remainder of the minutes value by six.
	logic        m_en, m_first, m_100, m_lon;
	logic [28:0] m_q_in, m_q_out;
	logic [2:0]  m_r_in, m_r_out;
	logic [9:0]  m_t;
	logic [21:0] m_prod;
	logic [7:0]  m_q6;

	function automatic logic [11:0] acc12(logic [11:0] a, logic [7:0] d);
		return (a * 12'd10) + 12'(d);
	endfunction

	function automatic logic [14:0] acc15(logic [14:0] a, logic [7:0] d);
		return (a * 15'd10) + 15'(d);
	endfunction

	assign dig = beat.data - CHAR_ZERO;
	// Non-final beats never touch the output register, so they drain during a stall.
	assign pop = beat_valid && (!beat.last || !valid_q || res_ready);
	assign beat_ready = pop;

	always_comb begin
		m_en    = 1'b0;
		m_first = 1'b0;
		m_100   = 1'b0;
		m_lon   = (beat.pos >= OFF_LON_MIN);
		unique case (beat.pos) inside
			OFF_LAT_MIN, OFF_LON_MIN: begin
				m_en    = 1'b1;
				m_first = 1'b1;
			end
			OFF_LAT_MIN + 7'd1, OFF_LAT_MIN + 7'd3, OFF_LAT_MIN + 7'd4,
			OFF_LAT_MIN + 7'd5, OFF_LAT_MIN + 7'd6,
			OFF_LON_MIN + 7'd1, OFF_LON_MIN + 7'd3, OFF_LON_MIN + 7'd4,
			OFF_LON_MIN + 7'd5, OFF_LON_MIN + 7'd6: begin
				m_en = 1'b1;
			end
			OFF_LAT_MIN + 7'd7, OFF_LON_MIN + 7'd7: begin
				m_en  = 1'b1;
				m_100 = 1'b1;
			end
			default: begin
				m_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		m_q_in  = m_first ? '0 : (m_lon ? sc_q.rec.lon_fraction : sc_q.rec.lat_fraction);
		m_r_in  = m_first ? '0 : (m_lon ? sc_q.lon_rem : sc_q.lat_rem);
		m_t     = (m_100 ? (10'(m_r_in) * 10'd100) : (10'(m_r_in) * 10'd10)) + 10'(dig);
		m_prod  = 22'(m_t) * 22'(RECIP6);
		m_q6    = m_prod[RECIP6_SH +: 8];
		m_r_out = 3'(m_t - (10'(m_q6) * 10'd6));
		m_q_out = (m_100 ? (m_q_in * 29'd100) : (m_q_in * 29'd10)) + 29'(m_q6);
	end

	always_comb begin
		sc_d = sc_q;
		unique case (beat.pos) inside
			OFF_HOUR:           sc_d.rec.hour        = 12'(dig);
			OFF_HOUR + 7'd1:    sc_d.rec.hour        = acc12(sc_q.rec.hour, dig);
			OFF_MINUTE:         sc_d.rec.minute      = 12'(dig);
			OFF_MINUTE + 7'd1:  sc_d.rec.minute      = acc12(sc_q.rec.minute, dig);
			OFF_SECOND:         sc_d.rec.second      = 12'(dig);
			OFF_SECOND + 7'd1:  sc_d.rec.second      = acc12(sc_q.rec.second, dig);
			OFF_LAT_DEG:        sc_d.rec.lat_degrees = 12'(dig);
			OFF_LAT_DEG + 7'd1: sc_d.rec.lat_degrees = acc12(sc_q.rec.lat_degrees, dig);
			OFF_HEMI:           sc_d.hemi_ok = (beat.data == CHAR_N) || (beat.data == CHAR_S);
			OFF_LON_DEG:        sc_d.rec.lon_degrees = 12'(dig);
			OFF_LON_DEG + 7'd1: sc_d.rec.lon_degrees = acc12(sc_q.rec.lon_degrees, dig);
			OFF_FIX:            sc_d.rec.fix_quality = dig;
			OFF_SATS:           sc_d.rec.satellites  = 12'(dig);
			OFF_SATS + 7'd1:    sc_d.rec.satellites  = acc12(sc_q.rec.satellites, dig);
			OFF_HDOP:           sc_d.rec.hdop        = 15'(dig);
			OFF_HDOP + 7'd2, OFF_HDOP + 7'd3: begin
				sc_d.rec.hdop = acc15(sc_q.rec.hdop, dig);
			end
			OFF_ALT:            sc_d.rec.altitude    = 15'(dig);
			OFF_ALT + 7'd1, OFF_ALT + 7'd2: begin
				sc_d.rec.altitude = acc15(sc_q.rec.altitude, dig);
			end
			default: begin
				sc_d = sc_q;
			end
		endcase
		if (m_en) begin
			if (m_lon) begin
				sc_d.rec.lon_fraction = m_q_out;
				sc_d.lon_rem          = m_r_out;
			end else begin
				sc_d.rec.lat_fraction = m_q_out;
				sc_d.lat_rem          = m_r_out;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sc_q <= sc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ok_q    <= 1'b0;
			rec_q   <= '0;
		end else begin
			if (pop && beat.last) begin
				valid_q <= 1'b1;
				ok_q    <= sc_d.hemi_ok;
				if (sc_d.hemi_ok) begin
					rec_q <= sc_d.rec;
				end else begin
					rec_q.fix_quality <= '0;
				end
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = valid_q;
	assign res_rec   = rec_q;
	assign res_ok    = ok_q;

endmodule

// ===== design/gga_sentence_field_extractor.sv =====
// GGA sentence field extractor.
// The slave stream carries one received character per beat in s_tdata. The block
// hunts for the letters GGA, then takes the next CAPTURE_BYTES characters as one
// capture and decodes time, latitude, longitude, fix, satellites, HDOP and
// altitude from fixed offsets. One master beat leaves per completed capture:
// m_tuser is 1 when the hemisphere letter was N or S and the fields were refreshed,
// 0 when the check failed, in which case the held record goes out with fix cleared.
// Throughput is one character per cycle while the beat queue has room; the limit
// is the per-byte digit accumulate in the back stage, including the shared
// divide-by-six step of the minutes fields. The last capture byte is written into
// the beat queue, and m_tvalid rises when the back stage pops it into the output
// register; a pending result that the receiver has not taken holds that pop back.
// Reset clears the header hunt, the capture count, the queue and the held record.
// When the receiver stalls, capture bytes keep draining into the back stage; only
// the final byte of the next capture waits, and once the four-entry queue fills,
// s_tready drops until the pending result is taken.
module gga_sentence_field_extractor #(
	parameter int CAPTURE_BYTES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] rx_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// [11:0] hour, [23:12] minute, [35:24] second, [47:36] lat_degrees,
	// [76:48] lat_fraction, [88:77] lon_degrees, [117:89] lon_fraction,
	// [125:118] fix_quality, [137:126] satellites, [152:138] hdop,
	// [167:153] altitude
	output logic [167:0] m_tdata,
	output logic [0:0]   m_tuser    // [0] ok
);
	import gsfe_pkg::*;

	// The front stage tags each captured byte with its offset in the capture.
	cap_beat_t push_beat, pop_beat;
	logic      push_valid, push_ready, pop_valid, pop_ready;
	rec_t      res_rec;
	logic      res_ok;

	gsfe_front #(
		.CAPTURE_BYTES(CAPTURE_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_beat (push_beat)
	);

	// A short queue lets the header hunt run on while the back stage waits.
	gsfe_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(push_valid),
		.wr_ready(push_ready),
		.wr_beat (push_beat),
		.rd_valid(pop_valid),
		.rd_ready(pop_ready),
		.rd_beat (pop_beat)
	);

	// The back stage accumulates the fields and owns the output register.
	gsfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_valid(pop_valid),
		.beat_ready(pop_ready),
		.beat      (pop_beat),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_rec   (res_rec),
		.res_ok    (res_ok)
	);

	assign m_tdata = {res_rec.altitude, res_rec.hdop, res_rec.satellites,
		res_rec.fix_quality, res_rec.lon_fraction, res_rec.lon_degrees,
		res_rec.lat_fraction, res_rec.lat_degrees, res_rec.second,
		res_rec.minute, res_rec.hour};
	assign m_tuser = res_ok;

endmodule

// ===== design/gsfe_checker.sv =====
`include "gga_sentence_field_extractor_defines.svh"

module gsfe_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [167:0] m_tdata,
	input logic [0:0]   m_tuser
);

	// A stalled result stays offered.
	`GSFE_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)

	// A stalled result does not change.
	`GSFE_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

	// A failed hemisphere check always reports no fix.
	`GSFE_ASSERT_SAME(a_fail_nofix, m_tvalid && !m_tuser[0], m_tdata[125:118] == 8'd0)

	// The divided minutes never exceed a bound above the largest quotient that digits reach.
	`GSFE_ASSERT_SAME(a_lat_range, m_tvalid, m_tdata[76:48] <= 29'd472221792)
	`GSFE_ASSERT_SAME(a_lon_range, m_tvalid, m_tdata[117:89] <= 29'd472221792)

endmodule

bind gga_sentence_field_extractor gsfe_checker u_gsfe_checker (.*);
